// File: hdl/oidl_pkg.sv
// ----------------------------------------------------------------------------
// oidl_pkg
// Shared types and codes for the ordered id list: item layouts, command and
// status codes, and the operation broadcast to the row of list cells.
// ----------------------------------------------------------------------------
package oidl_pkg;

    localparam int CMD_W  = 2;
    localparam int PID_W  = 16;
    localparam int STAT_W = 3;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_ENTRY   = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_ADDED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FAIL    = 3'd4;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_WRITE  = 2'd1;
    localparam cell_op_t OP_ROTATE = 2'd2;
    localparam cell_op_t OP_SHIFT  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PID_W-1:0] proc_id;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  proc_id_res;
        logic              last;
    } res_item_t;

endpackage

// File: hdl/ordered_id_list_append_remove.sv
// ----------------------------------------------------------------------------
// ordered_id_list_append_remove
// Ordered list of process ids, oldest first, with append, remove by key and
// listing, built as a row of cells that rotate the list past the head.
//
// Usage: commands enter on cmd/cmd_valid/cmd_stall, results leave on
// res/res_valid/res_stall; an item moves when valid is high and stall low.
// Append, list on an empty list, a remove on an empty list and an unknown
// command give one result, loaded into the output register in the cycle after the item.
// List gives count results, one per cycle while the receiver takes them,
// the final one marked last; the list rotates once through its cells.
// Remove scans the list past the head cell; a tail match or no match
// finishes there, otherwise the list rotates to the match, drops it and
// rotates back, then the result.
// One command is in work at a time: cmd_stall is high while a command is
// in work and while the output register holds a result that is stalled.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module ordered_id_list_append_remove
    import oidl_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LIST    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_SEEK    = 3'd3;
    localparam logic [2:0] S_RESTORE = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   fm_reg, fm_next;
    logic               found_reg, found_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    res_item_t          res_reg, res_next;
    logic               res_valid_reg;

    logic               slot_free;
    logic               accept;
    logic               load_res;
    logic [ID_BITS-1:0] key_in;
    logic [CNT_W-1:0]   cnt_m1;
    logic               at_end;
    logic               match;
    cell_op_t           cell_op;
    logic [ID_BITS-1:0] wr_id;
    logic [ID_BITS-1:0] cell_id [DEPTH];

    assign slot_free = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !slot_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign key_in    = ID_BITS'(cmd.proc_id);
    assign cnt_m1    = count_reg - CNT_ONE;
    assign at_end    = (CNT_W'(k_reg) == cnt_m1);
    assign match     = (cell_id[0] == key_reg);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        oidl_cell #(
            .IDX     (i),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .clk     (clk),
            .op      (cell_op),
            .cnt     (count_reg),
            .wr_id   (wr_id),
            .head_id (cell_id[0]),
            .next_id (cell_id[(i + 1 < DEPTH) ? i + 1 : i]),
            .id      (cell_id[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        fm_next     = fm_reg;
        found_next  = found_reg;
        key_next    = key_reg;
        status_next = status_reg;
        res_next    = res_reg;
        load_res    = 1'b0;
        cell_op     = OP_HOLD;
        wr_id       = key_in;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = key_in;
                    res_next.proc_id_res = PID_W'(key_in);
                    res_next.last        = 1'b1;
                    res_next.status      = ST_FAIL;
                    case (cmd.command)
                        CMD_APPEND:
                        begin
                            load_res = 1'b1;
                            if (count_reg != CNT_FULL)
                            begin
                                cell_op         = OP_WRITE;
                                count_next      = count_reg + CNT_ONE;
                                res_next.status = ST_ADDED;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                                load_res = 1'b1;
                            else
                            begin
                                state_next = S_SCAN;
                                k_next     = '0;
                                found_next = 1'b0;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                load_res             = 1'b1;
                                res_next.status      = ST_EMPTY;
                                res_next.proc_id_res = '0;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    load_res             = 1'b1;
                    res_next.status      = ST_ENTRY;
                    res_next.proc_id_res = PID_W'(cell_id[0]);
                    res_next.last        = at_end;
                    cell_op              = OP_ROTATE;
                    if (at_end)
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + IDX_ONE;
                end
            end
            S_SCAN:
            begin
                if (!at_end)
                begin
                    cell_op = OP_ROTATE;
                    k_next  = k_reg + IDX_ONE;
                    if (match && !found_reg)
                    begin
                        found_next = 1'b1;
                        fm_next    = k_reg;
                    end
                end
                else if (match)
                begin
                    cell_op     = OP_SHIFT;
                    count_next  = cnt_m1;
                    status_next = ST_REMOVED;
                    state_next  = S_RESP;
                end
                else
                begin
                    cell_op = OP_ROTATE;
                    if (found_reg)
                    begin
                        state_next = S_SEEK;
                        k_next     = '0;
                    end
                    else
                    begin
                        status_next = ST_FAIL;
                        state_next  = S_RESP;
                    end
                end
            end
            S_SEEK:
            begin
                if (k_reg == fm_reg)
                begin
                    cell_op     = OP_SHIFT;
                    count_next  = cnt_m1;
                    status_next = ST_REMOVED;
                    k_next      = '0;
                    if (fm_reg == '0)
                        state_next = S_RESP;
                    else
                        state_next = S_RESTORE;
                end
                else
                begin
                    cell_op = OP_ROTATE;
                    k_next  = k_reg + IDX_ONE;
                end
            end
            S_RESTORE:
            begin
                cell_op = OP_ROTATE;
                if (CNT_W'(k_reg) + CNT_W'(fm_reg) == cnt_m1)
                    state_next = S_RESP;
                else
                    k_next = k_reg + IDX_ONE;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    load_res             = 1'b1;
                    res_next.status      = status_reg;
                    res_next.proc_id_res = PID_W'(key_reg);
                    res_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        fm_reg     <= fm_next;
        found_reg  <= found_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        if (load_res)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("list count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_ONE) ||
        (count_reg == $past(count_reg) - CNT_ONE))
        else $error("list count moved by more than one");

    a_remove_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == CMD_REMOVE) && (count_reg != '0)) |=>
        (state_reg == S_SCAN))
        else $error("remove did not start a scan");

    a_partial_list: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.last) |-> (state_reg == S_LIST))
        else $error("non-final result outside a listing");

endmodule

// File: hdl/oidl_cell.sv
// ----------------------------------------------------------------------------
// oidl_cell
// One list position. Holds one id and, on the broadcast operation, takes the
// new id, its successor's id, or the head id when it is the tail.
// ----------------------------------------------------------------------------
module oidl_cell
    import oidl_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int ID_BITS = 16,
    parameter int CNT_W   = 5
)
(
    input  logic               clk,
    input  cell_op_t           op,
    input  logic [CNT_W-1:0]   cnt,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic [ID_BITS-1:0] head_id,
    input  logic [ID_BITS-1:0] next_id,
    output logic [ID_BITS-1:0] id
);

    localparam logic [CNT_W-1:0] POS    = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] POS_UP = CNT_W'(IDX + 1);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               is_slot;
    logic               is_tail;
    logic               below_tail;

    assign is_slot    = (cnt == POS);
    assign is_tail    = (cnt == POS_UP);
    assign below_tail = (POS_UP < cnt);

    always_comb
    begin
        id_next = id_reg;
        unique case (op)
            OP_HOLD:
            begin
                id_next = id_reg;
            end
            OP_WRITE:
            begin
                if (is_slot)
                    id_next = wr_id;
            end
            OP_ROTATE:
            begin
                if (below_tail)
                    id_next = next_id;
                else if (is_tail)
                    id_next = head_id;
            end
            OP_SHIFT:
            begin
                if (below_tail)
                    id_next = next_id;
            end
            default:
            begin
                id_next = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered id list. A scoreboard keeps its own copy
// of the list, predicts the results of every accepted command item and checks
// each result item in order. A short directed run covers empty, full,
// duplicate and unknown-command cases. Random traffic follows, with random
// gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
import oidl_pkg::*;

class id_list_scoreboard #(int SLOTS = 16);

    logic [PID_W-1:0] ids [SLOTS];
    int unsigned      count = 0;
    res_item_t        outcome_q [$];
    int unsigned      mismatches = 0;
    int unsigned      results_checked = 0;
    int unsigned      full_appends = 0;
    int unsigned      removes_hit = 0;
    int unsigned      removes_missed = 0;
    int unsigned      listings = 0;

    function void add_outcome(logic [STAT_W-1:0] st, logic [PID_W-1:0] id, logic lst);
        res_item_t r;
        r.status      = st;
        r.proc_id_res = id;
        r.last        = lst;
        outcome_q.push_back(r);
    endfunction

    function void note_cmd(cmd_item_t c);
        int hit;
        int i;
        hit = -1;
        case (c.command)
            CMD_APPEND:
            begin
                if (count == SLOTS)
                begin
                    full_appends++;
                    add_outcome(ST_FAIL, c.proc_id, 1'b1);
                end
                else
                begin
                    ids[count] = c.proc_id;
                    count++;
                    add_outcome(ST_ADDED, c.proc_id, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (count > 0 && ids[count-1] == c.proc_id)
                    hit = int'(count) - 1;
                for (i = 0; hit < 0 && i + 1 < int'(count); i++)
                    if (ids[i] == c.proc_id)
                        hit = i;
                if (hit < 0)
                begin
                    removes_missed++;
                    add_outcome(ST_FAIL, c.proc_id, 1'b1);
                end
                else
                begin
                    for (i = hit; i + 1 < int'(count); i++)
                        ids[i] = ids[i+1];
                    count--;
                    removes_hit++;
                    add_outcome(ST_REMOVED, c.proc_id, 1'b1);
                end
            end
            CMD_LIST:
            begin
                listings++;
                if (count == 0)
                    add_outcome(ST_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < int'(count); i++)
                        add_outcome(ST_ENTRY, ids[i], i + 1 == int'(count));
            end
            default:
                add_outcome(ST_FAIL, c.proc_id, 1'b1);
        endcase
    endfunction

    function void check_res(res_item_t r);
        res_item_t exp_r;
        results_checked++;
        if (outcome_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status=%0d id=%h last=%b",
                         r.status, r.proc_id_res, r.last);
        end
        else
        begin
            exp_r = outcome_q.pop_front();
            if (r.status !== exp_r.status || r.proc_id_res !== exp_r.proc_id_res ||
                r.last !== exp_r.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("res %0d: expected st=%0d id=%h last=%b, got st=%0d id=%h last=%b",
                             results_checked, exp_r.status, exp_r.proc_id_res, exp_r.last,
                             r.status, r.proc_id_res, r.last);
            end
        end
    endfunction

    function int unsigned pending();
        return outcome_q.size();
    endfunction

endclass

module testbench;

    localparam int LIST_DEPTH = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;

    id_list_scoreboard #(LIST_DEPTH) sb;
    bit          no_idle;
    int unsigned cmds_sent;

    ordered_id_list_append_remove #(
        .DEPTH   (LIST_DEPTH),
        .ID_BITS (PID_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            sb.note_cmd(cmd);
        if (rst_n && res_valid && !res_stall)
            sb.check_res(res);
    end

    initial
    begin
        int hold;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 15);
            repeat (hold)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
            end
            @(negedge clk);
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [PID_W-1:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid     <= 1'b1;
        cmd.command   <= op;
        cmd.proc_id   <= id;
        do @(posedge clk); while (cmd_stall);
        cmds_sent++;
    endtask

    initial
    begin
        logic [PID_W-1:0] pool [6];
        logic [PID_W-1:0] id;
        int               seg;
        int               k;
        int               grow;
        int               roll;

        sb        = new;
        no_idle   = 1'b0;
        cmds_sent = 0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(CMD_LIST, 16'hBEEF);
        send_cmd(CMD_REMOVE, 16'h1234);
        send_cmd(CMD_UNUSED, 16'hFFFF);
        send_cmd(CMD_APPEND, 16'h0000);
        send_cmd(CMD_APPEND, 16'hFFFF);
        send_cmd(CMD_APPEND, 16'hA5A5);
        send_cmd(CMD_APPEND, 16'h5A5A);
        send_cmd(CMD_APPEND, 16'h0001);
        send_cmd(CMD_APPEND, 16'hA5A5);
        for (k = 0; k < 9; k++)
            send_cmd(CMD_APPEND, PID_W'(16'h1000 + k));
        send_cmd(CMD_APPEND, 16'h0001);
        send_cmd(CMD_APPEND, 16'h7777);
        send_cmd(CMD_LIST, 16'h0000);
        send_cmd(CMD_REMOVE, 16'h0001);
        send_cmd(CMD_REMOVE, 16'hA5A5);
        send_cmd(CMD_REMOVE, 16'h4321);
        send_cmd(CMD_LIST, 16'hFFFF);

        for (k = 0; k < 6; k++)
            pool[k] = PID_W'($urandom);

        for (seg = 0; seg < 10; seg++)
        begin
            no_idle = (seg % 3 == 1);
            grow    = (seg % 2 == 0) ? 70 : 25;
            for (k = 0; k < 30; k++)
            begin
                roll = $urandom_range(0, 99);
                id   = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, 5)]
                                                    : PID_W'($urandom);
                if (roll < grow)
                    send_cmd(CMD_APPEND, id);
                else if (roll < 92)
                begin
                    if (sb.count > 0 && $urandom_range(0, 99) < 80)
                        id = sb.ids[$urandom_range(0, sb.count - 1)];
                    send_cmd(CMD_REMOVE, id);
                end
                else if (roll < 97)
                    send_cmd(CMD_LIST, id);
                else
                    send_cmd(CMD_UNUSED, id);
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * LIST_DEPTH + 8) @(posedge clk);

        $display("run covered %0d commands and %0d results: %0d listings, %0d removes hit,",
                 cmds_sent, sb.results_checked, sb.listings, sb.removes_hit);
        $display("%0d removes missed, %0d appends to a full list, %0d mismatches",
                 sb.removes_missed, sb.full_appends, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
